// ===== sv/kts_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kts_pkg: shared types and constants of the keyed table
// Entry layout, ring commands, operation and status codes, text helper.
// ---------------------------------------------------------------------------
package kts_pkg;

	localparam int DEPTH      = 16;
	localparam int KEY_BYTES  = 8;
	localparam int KIND_BYTES = 8;
	localparam int CW         = $clog2(DEPTH + 1);
	localparam int CMPW       = 5;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_LIST   = 3'd2;
	localparam logic [2:0] OP_SEQ    = 3'd3;
	localparam logic [2:0] OP_BIN    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NF    = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [63:0] name;
		logic [63:0] kind;
		logic [15:0] amount;
	} entry_t;

	// One ring move: pop the head, push an entry at the tail, or both.
	typedef struct packed {
		logic   pop;
		logic   push;
		entry_t data;
	} ring_cmd_t;

	// Keep the first nbytes characters and clear everything after the first NUL.
	function automatic logic [63:0] norm_text(input logic [63:0] v, input int nbytes);
		logic [63:0] r;
		logic        stop;
		logic [7:0]  ch;
		r    = '0;
		stop = 1'b0;
		for (int b = 0; b < 8; b++) begin
			ch = v[63 - 8 * b -: 8];
			if (b >= nbytes || ch == 8'd0) begin
				stop = 1'b1;
			end
			if (!stop) begin
				r[63 - 8 * b -: 8] = ch;
			end
		end
		return r;
	endfunction

endpackage

// ===== sv/keyed_table_sort_search.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyed_table_sort_search: keyed table with list, search and sort
// Sequencer over a ring of table cells, with one output register.
// ---------------------------------------------------------------------------
// One request is worked at a time; every table walk rotates the ring of
// cells one entry per cycle, while a list walk also waits on output stalls.
// Sort then binary search runs the in-place exchange sort, which streams a
// held entry against the ring, then probes, each probe being one full
// rotation. A finished result waits in the output register while the next
// request is taken.
module keyed_table_sort_search
	import kts_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata: key_name[63:0], kind_text[127:64], amount[143:128]
	input  logic [143:0] s_tdata,
	// s_tuser: op[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata: found_name[63:0], found_kind[127:64], found_amount[143:128],
	// compares[148:144], zero fill[151:149]
	output logic [151:0] m_tdata,
	// m_tuser: status[1:0]
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	typedef enum logic [3:0] {
		IDLE, REM, LIST, SEQ, S_POP, S_CMP, S_PASS, S_PUSH, BIN_ROT, BIN_CHK, DONE
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   n_q, cnt_q, i_q, j_q, lo_q, hi_q, mid_q;
	logic [CMPW-1:0] probes_q, res_cmp_q;
	logic            found_q;
	logic [63:0]     key_q;
	entry_t          h_q, res_entry_q;
	logic [1:0]      res_status_q;
	logic            m_valid_q, m_last_q;
	logic [1:0]      m_status_q;
	entry_t          m_entry_q;
	logic [CMPW-1:0] m_cmp_q;

	ring_cmd_t       cmd;
	entry_t          head;
	logic [CW-1:0]   len;
	logic            accept, can_emit, emit, hit, at_end;
	logic [CW:0]     mid_sum;

	kts_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (head),
		.len    (len)
	);

	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;
	assign can_emit = !m_valid_q || m_tready;
	assign emit     = can_emit && (state_q == LIST || state_q == DONE);
	assign hit      = (head.name == key_q);
	assign at_end   = (cnt_q == n_q - 1'b1);
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - 1'b1;

	// Ring moves for each state.
	always_comb begin
		cmd.pop  = 1'b0;
		cmd.push = 1'b0;
		cmd.data = head;
		case (state_q)
			IDLE: begin
				if (accept && s_tuser == OP_INSERT && len < CW'(DEPTH)) begin
					cmd.push        = 1'b1;
					cmd.data.name   = norm_text(s_tdata[63:0], KEY_BYTES);
					cmd.data.kind   = norm_text(s_tdata[127:64], KIND_BYTES);
					cmd.data.amount = s_tdata[143:128];
				end
			end
			REM: begin
				cmd.pop  = 1'b1;
				cmd.push = !(hit && !found_q);
			end
			LIST: begin
				cmd.pop  = can_emit;
				cmd.push = can_emit;
			end
			SEQ, S_PASS, BIN_ROT: begin
				cmd.pop  = 1'b1;
				cmd.push = 1'b1;
			end
			S_POP: begin
				cmd.pop = 1'b1;
			end
			S_CMP: begin
				cmd.pop  = 1'b1;
				cmd.push = 1'b1;
				cmd.data = (h_q.name > head.name) ? h_q : head;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				cmd.data = h_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			m_valid_q <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						key_q       <= norm_text(s_tdata[63:0], KEY_BYTES);
						n_q         <= len;
						cnt_q       <= '0;
						i_q         <= '0;
						found_q     <= 1'b0;
						res_entry_q <= '0;
						res_cmp_q   <= '0;
						case (s_tuser)
							OP_INSERT: begin
								res_status_q <= (len >= CW'(DEPTH)) ? ST_FULL : ST_OK;
								state_q      <= DONE;
							end
							OP_REMOVE: begin
								if (len == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= DONE;
								end else begin
									state_q <= REM;
								end
							end
							OP_LIST: begin
								if (len == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= DONE;
								end else begin
									state_q <= LIST;
								end
							end
							OP_SEQ: begin
								res_status_q <= ST_NF;
								state_q      <= (len == '0) ? DONE : SEQ;
							end
							OP_BIN: begin
								res_status_q <= ST_NF;
								state_q      <= (len == '0) ? DONE : S_POP;
							end
							default: begin
							end
						endcase
					end
				end
				REM: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					if (at_end) begin
						res_status_q <= (found_q || hit) ? ST_OK : ST_NF;
						state_q      <= DONE;
					end
				end
				LIST: begin
					if (can_emit) begin
						m_status_q <= ST_OK;
						m_entry_q  <= head;
						m_cmp_q    <= '0;
						m_last_q   <= at_end;
						cnt_q      <= cnt_q + 1'b1;
						if (at_end) begin
							state_q <= IDLE;
						end
					end
				end
				SEQ: begin
					if (hit && !found_q) begin
						found_q      <= 1'b1;
						res_entry_q  <= head;
						res_cmp_q    <= CMPW'(cnt_q + 1'b1);
						res_status_q <= ST_OK;
					end
					cnt_q <= cnt_q + 1'b1;
					if (at_end) begin
						if (!(found_q || hit)) begin
							res_cmp_q <= CMPW'(n_q);
						end
						state_q <= DONE;
					end
				end
				S_POP: begin
					h_q <= head;
					cnt_q <= '0;
					if (i_q + 1'b1 < n_q) begin
						j_q     <= i_q + 1'b1;
						state_q <= S_CMP;
					end else begin
						state_q <= (i_q != '0) ? S_PASS : S_PUSH;
					end
				end
				S_CMP: begin
					if (h_q.name > head.name) begin
						h_q <= head;
					end
					j_q <= j_q + 1'b1;
					if (j_q == n_q - 1'b1) begin
						state_q <= (i_q != '0) ? S_PASS : S_PUSH;
					end
				end
				S_PASS: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == i_q - 1'b1) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (i_q + 1'b1 == n_q) begin
						lo_q     <= '0;
						hi_q     <= n_q;
						probes_q <= '0;
						state_q  <= BIN_CHK;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_POP;
					end
				end
				BIN_ROT: begin
					if (cnt_q == mid_q) begin
						probes_q <= probes_q + 1'b1;
						if (hit) begin
							found_q     <= 1'b1;
							res_entry_q <= head;
						end else if (head.name < key_q) begin
							lo_q <= mid_q + 1'b1;
						end else begin
							hi_q <= mid_q;
						end
					end
					cnt_q <= cnt_q + 1'b1;
					if (at_end) begin
						state_q <= BIN_CHK;
					end
				end
				BIN_CHK: begin
					if (found_q || lo_q >= hi_q) begin
						res_status_q <= found_q ? ST_OK : ST_NF;
						res_cmp_q    <= probes_q;
						state_q      <= DONE;
					end else begin
						mid_q   <= mid_sum[CW:1];
						cnt_q   <= '0;
						state_q <= BIN_ROT;
					end
				end
				DONE: begin
					if (can_emit) begin
						m_status_q <= res_status_q;
						m_entry_q  <= res_entry_q;
						m_cmp_q    <= res_cmp_q;
						m_last_q   <= 1'b1;
						state_q    <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {3'b000, m_cmp_q, m_entry_q.amount, m_entry_q.kind, m_entry_q.name};

	// The table never holds more entries than it has cells.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len <= CW'(DEPTH))
		else $error("table length beyond depth");

	// An insert into a full table leaves the length alone.
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == OP_INSERT && len == CW'(DEPTH) |=> len == CW'(DEPTH))
		else $error("insert into full table changed length");

	// An empty-table result is always the final result of its request.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_status_q == ST_EMPTY |-> m_last_q)
		else $error("empty status without last");

	// A full status is only reported while the table is full.
	a_idle_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DONE && res_status_q == ST_FULL |-> len == CW'(DEPTH))
		else $error("full status with room left");

endmodule

// ===== sv/kts_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kts_cell: one table slot of the ring
// Holds one entry; takes its upper neighbor on a pop or the bus on a push.
// ---------------------------------------------------------------------------
module kts_cell
	import kts_pkg::*;
(
	input  logic          clk,
	input  logic [CW-1:0] idx,
	input  logic [CW-1:0] len,
	input  ring_cmd_t     cmd,
	input  entry_t        nxt,
	output entry_t        ent
);

	logic [CW:0] pos1;
	logic        take_next;
	logic        take_bus;

	// The slot after this one decides whether it is inside the ring.
	assign pos1      = {1'b0, idx} + 1'b1;
	assign take_next = cmd.pop && (pos1 < {1'b0, len});
	assign take_bus  = cmd.push && (cmd.pop ? (pos1 == {1'b0, len}) : (idx == len));

	always_ff @(posedge clk) begin
		if (take_bus) begin
			ent <= cmd.data;
		end else if (take_next) begin
			ent <= nxt;
		end
	end

endmodule

// ===== sv/kts_chain.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kts_chain: row of table cells and the ring length
// Every pop shifts the ring one place toward the head cell; a lone push fills the tail.
// ---------------------------------------------------------------------------
module kts_chain
	import kts_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  ring_cmd_t     cmd,
	output entry_t        head,
	output logic [CW-1:0] len
);

	entry_t        ents [DEPTH];
	logic [CW-1:0] len_q;

	// Row of cells, each fed by its upper neighbor.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		entry_t nxt;
		if (k == DEPTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = ents[k + 1];
		end
		kts_cell u_cell (
			.clk (clk),
			.idx (CW'(k)),
			.len (len_q),
			.cmd (cmd),
			.nxt (nxt),
			.ent (ents[k])
		);
	end

	// Ring length follows pushes and pops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.push && !cmd.pop) begin
			len_q <= len_q + 1'b1;
		end else if (cmd.pop && !cmd.push) begin
			len_q <= len_q - 1'b1;
		end
	end

	assign head = ents[0];
	assign len  = len_q;

endmodule

// ===== tb/tb_keyed_table_sort_search.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_keyed_table_sort_search: self-checking bench of the keyed table
// Drives insert, remove, list, search and unknown-op requests with random
// gaps, keeps its own table to predict every result, compares field by field.
// ---------------------------------------------------------------------------
module tb_keyed_table_sort_search;
	import kts_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] name;
		logic [63:0] kind;
		logic [15:0] amount;
		logic [4:0]  compares;
		logic        last;
	} table_result_t;

	int cycle_count;

	// Table predictor and the queue of results it expects.
	class table_scoreboard;
		logic [63:0] names [DEPTH];
		logic [63:0] kinds [DEPTH];
		logic [15:0] amounts [DEPTH];
		int count;
		table_result_t pending_results [$];
		int errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function logic [63:0] clip_text(logic [63:0] v);
			logic [63:0] r;
			bit stop;
			r = '0;
			stop = 0;
			for (int b = 0; b < 8; b++) begin
				if (v[63 - 8 * b -: 8] == 8'd0) stop = 1;
				if (!stop) r[63 - 8 * b -: 8] = v[63 - 8 * b -: 8];
			end
			return r;
		endfunction

		function void add_result(logic [1:0] st, int idx, bit hit, int cmp, bit lst);
			table_result_t r;
			r.status = st;
			r.name = hit ? names[idx] : '0;
			r.kind = hit ? kinds[idx] : '0;
			r.amount = hit ? amounts[idx] : '0;
			r.compares = cmp[4:0];
			r.last = lst;
			pending_results.push_back(r);
		endfunction

		// Print one mismatch line and count it.
		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
				cycle_count);
			errors++;
		endtask

		// Apply one accepted request to the table copy.
		function void note_request(logic [2:0] op, logic [63:0] kn, logic [63:0] kt,
				logic [15:0] amt);
			logic [63:0] key;
			logic [63:0] tn, tk;
			logic [15:0] ta;
			int lo, hi, mid, probes;
			bit done;
			key = clip_text(kn);
			done = 0;
			case (op)
				OP_INSERT: begin
					if (count >= DEPTH) begin
						add_result(ST_FULL, 0, 0, 0, 1);
					end else begin
						names[count] = key;
						kinds[count] = clip_text(kt);
						amounts[count] = amt;
						count++;
						add_result(ST_OK, 0, 0, 0, 1);
					end
				end
				OP_REMOVE: begin
					if (count == 0) begin
						add_result(ST_EMPTY, 0, 0, 0, 1);
					end else begin
						for (int i = 0; i < count && !done; i++) begin
							if (names[i] == key) begin
								for (int j = i; j + 1 < count; j++) begin
									names[j] = names[j + 1];
									kinds[j] = kinds[j + 1];
									amounts[j] = amounts[j + 1];
								end
								count--;
								done = 1;
							end
						end
						add_result(done ? ST_OK : ST_NF, 0, 0, 0, 1);
					end
				end
				OP_LIST: begin
					if (count == 0) add_result(ST_EMPTY, 0, 0, 0, 1);
					for (int i = 0; i < count; i++)
						add_result(ST_OK, i, 1, 0, i + 1 == count);
				end
				OP_SEQ: begin
					for (int i = 0; i < count && !done; i++) begin
						if (names[i] == key) begin
							add_result(ST_OK, i, 1, i + 1, 1);
							done = 1;
						end
					end
					if (!done) add_result(ST_NF, 0, 0, count, 1);
				end
				OP_BIN: begin
					// Exchange sort, kept in place.
					for (int i = 0; i + 1 < count; i++) begin
						for (int j = i + 1; j < count; j++) begin
							if (names[i] > names[j]) begin
								tn = names[i]; tk = kinds[i]; ta = amounts[i];
								names[i] = names[j]; kinds[i] = kinds[j];
								amounts[i] = amounts[j];
								names[j] = tn; kinds[j] = tk; amounts[j] = ta;
							end
						end
					end
					lo = 0;
					hi = count - 1;
					probes = 0;
					while (lo <= hi && !done) begin
						mid = (lo + hi) / 2;
						probes++;
						if (names[mid] == key) begin
							add_result(ST_OK, mid, 1, probes, 1);
							done = 1;
						end else if (names[mid] < key) begin
							lo = mid + 1;
						end else begin
							hi = mid - 1;
						end
					end
					if (!done) add_result(ST_NF, 0, 0, probes, 1);
				end
				default: ;
			endcase
		endfunction

		task check_result(table_result_t got);
			table_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected", '0, '0);
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.name !== want.name) report_mismatch("found_name", got.name, want.name);
			if (got.kind !== want.kind) report_mismatch("found_kind", got.kind, want.kind);
			if (got.amount !== want.amount)
				report_mismatch("found_amount", 64'(got.amount), 64'(want.amount));
			if (got.compares !== want.compares)
				report_mismatch("compares", 64'(got.compares), 64'(want.compares));
			if (got.last !== want.last)
				report_mismatch("last", 64'(got.last), 64'(want.last));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [151:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	table_scoreboard board;
	bit calm_phase;
	logic [63:0] name_pool [8];

	keyed_table_sort_search DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Cycle limit.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 600000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Result side: random stall bursts, check on each accepted result.
	initial begin
		table_result_t got;
		m_tready = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.name = m_tdata[63:0];
				got.kind = m_tdata[127:64];
				got.amount = m_tdata[143:128];
				got.compares = m_tdata[148:144];
				got.last = m_tlast;
				board.check_result(got);
			end
			if (!calm_phase && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				m_tready <= 1;
			end else begin
				m_tready <= 1;
			end
		end
	end

	// Send one request and wait for its acceptance.
	task automatic send_request(logic [2:0] op, logic [63:0] kn, logic [63:0] kt,
			logic [15:0] amt);
		if (!calm_phase && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {amt, kt, kn};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		board.note_request(op, kn, kt, amt);
	endtask

	function automatic logic [63:0] pick_name();
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0, 1: v = name_pool[$urandom_range(0, 7)];
			2: v = {$urandom, $urandom};
			default: begin
				// Text with garbage after a NUL, which must compare equal.
				v = name_pool[$urandom_range(0, 7)];
				if (v[31:24] == 8'd0) v[23:0] = 24'($urandom);
			end
		endcase
		return v;
	endfunction

	initial begin
		int op_pick;
		board = new();
		calm_phase = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = OP_INSERT;
		for (int i = 0; i < 8; i++)
			name_pool[i] = {8'h41 + i[7:0], 8'h61 + i[7:0], 8'h62, 8'h00, 32'h0};
		name_pool[6] = 64'hFFFF_FFFF_FFFF_FFFF;
		name_pool[7] = 64'h0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty table cases, fill to full, list, searches, removes, unknown ops.
		send_request(OP_REMOVE, name_pool[0], '0, '0);
		send_request(OP_LIST, '0, '0, '0);
		send_request(OP_SEQ, name_pool[0], '0, '0);
		send_request(OP_BIN, name_pool[0], '0, '0);
		for (int i = 0; i < 17; i++)
			send_request(OP_INSERT, (i % 2) ? name_pool[i % 8] : {$urandom, $urandom},
				(i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom},
				(i == 0) ? 16'hFFFF : i[15:0]);
		send_request(OP_LIST, '0, '0, '0);
		send_request(OP_SEQ, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
		send_request(OP_BIN, name_pool[3], '0, '0);
		send_request(OP_BIN, 64'h0000_0000_0000_0001, '0, '0);
		send_request(OP_REMOVE, name_pool[1], '0, '0);
		send_request(3'd5, '0, '0, '0);
		send_request(3'd7, '0, '0, '0);

		// Random traffic; keep the table size wandering over its full range.
		for (int n = 0; n < 330; n++) begin
			if (n > 280) calm_phase = 1;
			op_pick = $urandom_range(0, 19);
			if (op_pick < 6)
				send_request(OP_INSERT, pick_name(), {$urandom, $urandom}, 16'($urandom));
			else if (op_pick < 10) send_request(OP_REMOVE, pick_name(), '0, '0);
			else if (op_pick < 12) send_request(OP_LIST, {$urandom, $urandom}, '0, '0);
			else if (op_pick < 15)
				send_request(OP_SEQ, pick_name(), {$urandom, $urandom}, 16'($urandom));
			else if (op_pick < 19)
				send_request(OP_BIN, pick_name(), {$urandom, $urandom}, 16'($urandom));
			else send_request(3'($urandom_range(5, 7)), pick_name(), '0, '0);
		end
		s_tvalid <= 0;

		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/kts_pkg.sv
sv/kts_cell.sv
sv/kts_chain.sv
sv/keyed_table_sort_search.sv
tb/tb_keyed_table_sort_search.sv
